// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/bcpe_pkg.sv =====
package bcpe_pkg;

  localparam int CFG_AW     = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_DEGREE      = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  localparam logic [1:0] CMD_LOAD_KNOT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_POINT = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_BAD_U     = 2'd2;

  localparam logic [1:0] COORD_X = 2'd0;
  localparam logic [1:0] COORD_Y = 2'd1;
  localparam logic [1:0] COORD_Z = 2'd2;

  localparam int SEARCH_LIMIT = 32;
  localparam int IT_W         = $clog2(SEARCH_LIMIT + 1);

  // basis values are unsigned q1.30
  localparam int NB_W  = 31;
  localparam logic [NB_W-1:0] ONE_Q30 = 31'h4000_0000;

  // divider: 63-bit dividend, 33-bit divisor, quotient below 2^31
  localparam int DVD_W = 63;
  localparam int DVS_W = 33;
  localparam int QUO_W = NB_W;

  // coordinate sum with 46 fraction bits, rounding to q16.16
  localparam int ACC_W = 68;
  localparam int RQ_W  = ACC_W - 30;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 68'sh0_0000_0000_2000_0000;
  localparam logic signed [RQ_W-1:0]  RQ_MAX     = 38'sh00_7FFF_FFFF;
  localparam logic signed [RQ_W-1:0]  RQ_MIN     = 38'sh3F_8000_0000;

  typedef struct packed {
    logic [1:0]         command;
    logic [6:0]         entry_index;
    logic [31:0]        knot_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        param_u;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [6:0]         span_found;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RNG_LO,
    ST_RNG_HI,
    ST_SRCH_A,
    ST_SRCH_B,
    ST_BAS_ISS,
    ST_BAS_L,
    ST_BAS_R,
    ST_DEN,
    ST_MUL_R,
    ST_DIV_R,
    ST_MUL_L,
    ST_DIV_L,
    ST_W_RD,
    ST_W_MUL,
    ST_W_ACC,
    ST_W_RND,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/bcpe_div.sv =====
module bcpe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bcpe_pkg::DVD_W-1:0]  dividend,
  input  logic [bcpe_pkg::DVS_W-1:0]  divisor,
  output logic [bcpe_pkg::QUO_W-1:0]  quotient,
  output logic                        done
);
  import bcpe_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [QUO_W-1:0] low_r, quo_r;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DVS_W'(dividend[DVD_W-1:QUO_W]);
      low_r <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== hdl/bspline_curve_point_eval_core.sv =====
// channel   direction  handshake                payload
// in_       input      in_valid / in_stall      bcpe_pkg::in_item_t
// out_      output     out_valid / out_stall    bcpe_pkg::out_item_t
// apb       input      psel penable pwrite      paddr / pwdata / prdata, pready tied high
//
// one transaction at a time; in_stall is high from acceptance until the result is registered
// loads: result registered in ST_OUT after ST_DECODE, once the output register is free
// evaluate: range checks, binary span search, the basis triangle and the weighted sum,
//   paced by the bit-serial divider shared by all basis divisions
// sync reset clears state and out_valid, presets degree 3, point count 4; payload and stores not cleared
// a new transaction is taken while a finished result still waits under out_stall
module bspline_curve_point_eval_core #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DEGREE = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bcpe_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bcpe_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcpe_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bcpe_pkg::*;

  localparam int KDEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int CAW    = $clog2(MAX_POINTS);
  localparam int DW     = $clog2(MAX_DEGREE + 1);

  // control state
  state_t     state_r, state_nxt;
  logic       out_valid_r;
  logic [1:0] deg_r;
  logic [6:0] pc_r;

  // payload state
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt, out_data_r;
  logic [KAW-1:0]   low_r, low_nxt, high_r, high_nxt, span_r, span_nxt;
  logic [IT_W-1:0]  iter_r, iter_nxt;
  logic [DW-1:0]    j_r, j_nxt, r_r, r_nxt, k_r, k_nxt;
  logic [1:0]       c_r, c_nxt;
  logic [NB_W-1:0]  saved_r, saved_nxt, cur_r, cur_nxt;
  logic [DVS_W-1:0] den_r, den_nxt;
  logic [31:0]      rtv_r, rtv_nxt, lfv_r, lfv_nxt;
  logic [NB_W-1:0]  nb_r [MAX_DEGREE+1];
  logic [NB_W-1:0]  nb_nxt [MAX_DEGREE+1];
  logic [31:0]      lf_r [MAX_DEGREE+1];
  logic [31:0]      lf_nxt [MAX_DEGREE+1];
  logic [31:0]      rt_r [MAX_DEGREE+1];
  logic [31:0]      rt_nxt [MAX_DEGREE+1];
  logic signed [65:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  // stores
  logic [31:0]        knot_mem [KDEPTH];
  logic [31:0]        cx_mem [MAX_POINTS];
  logic [31:0]        cy_mem [MAX_POINTS];
  logic [31:0]        cz_mem [MAX_POINTS];
  logic [31:0]        knot_q_r;
  logic signed [31:0] cx_q_r, cy_q_r, cz_q_r;
  logic [KAW-1:0]     knot_addr;
  logic [CAW-1:0]     ctrl_addr;
  logic               knot_we, ctrl_we;

  // decisions and shared datapath
  logic               accept, out_load, cfg_wr;
  logic [DW-1:0]      p_d;
  logic [KAW-1:0]     p_k, n_k, j_k;
  logic               cfg_bad, idx_k_ok, idx_c_ok;
  logic [31:0]        u;
  logic               u_lt, u_gt, iter_full, r_last;
  logic [KAW:0]       sum_pn, sum_ls, sum_sh;
  logic [KAW-1:0]     mid_pn, mid_ls, mid_sh;
  logic [31:0]        rt_sel, lf_sel;
  logic [DVS_W-1:0]   den_c;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] coord_sel;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [RQ_W-1:0]  rnd_q;
  logic signed [31:0] sat_val;
  logic               div_start, div_done;
  logic [QUO_W-1:0]   div_quo;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign cfg_wr   = psel && penable && pwrite && pready;

  // configuration port, no wait states
  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_POINT_COUNT) ? 32'(pc_r) : 32'(deg_r);

  assign p_d = DW'(deg_r);
  assign p_k = KAW'(deg_r);
  assign n_k = KAW'(pc_r);
  assign j_k = KAW'(j_r);
  assign u   = item_r.param_u;

  assign cfg_bad = (32'(deg_r) > 32'(MAX_DEGREE)) || (32'(pc_r) < 32'(deg_r) + 32'd1) ||
                   (32'(pc_r) > 32'(MAX_POINTS));
  assign idx_k_ok = 32'(item_r.entry_index) < 32'(KDEPTH);
  assign idx_c_ok = 32'(item_r.entry_index) < 32'(MAX_POINTS);

  // comparisons against the knot just read
  assign u_lt      = u < knot_q_r;
  assign u_gt      = u > knot_q_r;
  assign iter_full = 32'(iter_r) >= 32'(SEARCH_LIMIT);

  // midpoints of the binary span search
  assign sum_pn = {1'b0, p_k} + {1'b0, n_k};
  assign sum_ls = {1'b0, low_r} + {1'b0, span_r};
  assign sum_sh = {1'b0, span_r} + {1'b0, high_r};
  assign mid_pn = sum_pn[KAW:1];
  assign mid_ls = sum_ls[KAW:1];
  assign mid_sh = sum_sh[KAW:1];

  // triangle step operands: right[r+1] and left[j-r]
  assign rt_sel = rt_r[r_r + DW'(1)];
  assign lf_sel = lf_r[j_r - r_r];
  assign den_c  = {1'b0, rt_sel} + {1'b0, lf_sel};
  assign r_last = (r_r + DW'(1)) == j_r;

  // weighted sum reads base span-p plus k from all three point stores
  assign ctrl_addr = CAW'(span_r - p_k + KAW'(k_r));

  // rounding half up to q16.16 and saturation
  assign rnd_sum = acc_r + ROUND_HALF;
  assign rnd_q   = rnd_sum[ACC_W-1:30];
  always_comb begin
    if (rnd_q > RQ_MAX) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (rnd_q < RQ_MIN) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = rnd_q[31:0];
    end
  end

  always_comb begin
    case (c_r)
      COORD_X: coord_sel = cx_q_r;
      COORD_Y: coord_sel = cy_q_r;
      default: coord_sel = cz_q_r;
    endcase
  end

  // the one shared multiplier: basis times distance, or basis times coordinate
  always_comb begin
    mul_a = {2'b00, cur_r};
    mul_b = {1'b0, rtv_r};
    case (state_r)
      ST_MUL_L: begin
        mul_b = {1'b0, lfv_r};
      end
      ST_W_MUL: begin
        mul_a = {2'b00, nb_r[k_r]};
        mul_b = 33'(coord_sel);
      end
      default: begin
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  bcpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[DVD_W-1:0]),
    .divisor  (den_r),
    .quotient (div_quo),
    .done     (div_done)
  );

  // stores: one write port, registered read
  always_ff @(posedge clk) begin
    if (knot_we) begin
      knot_mem[KAW'(item_r.entry_index)] <= item_r.knot_value;
    end
    knot_q_r <= knot_mem[knot_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      cx_mem[CAW'(item_r.entry_index)] <= item_r.coord_x;
      cy_mem[CAW'(item_r.entry_index)] <= item_r.coord_y;
      cz_mem[CAW'(item_r.entry_index)] <= item_r.coord_z;
    end
    cx_q_r <= cx_mem[ctrl_addr];
    cy_q_r <= cy_mem[ctrl_addr];
    cz_q_r <= cz_mem[ctrl_addr];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (item_r.command == CMD_EVAL && !cfg_bad) state_nxt = ST_RNG_LO;
        else state_nxt = ST_OUT;
      end
      ST_RNG_LO: state_nxt = u_lt ? ST_OUT : ST_RNG_HI;
      ST_RNG_HI: begin
        if (u_gt) state_nxt = ST_OUT;
        else if (!u_lt) state_nxt = ST_BAS_ISS;
        else state_nxt = ST_SRCH_A;
      end
      ST_SRCH_A: begin
        if (u_lt) state_nxt = iter_full ? ST_OUT : ST_SRCH_A;
        else state_nxt = ST_SRCH_B;
      end
      ST_SRCH_B: begin
        if (!u_lt) state_nxt = iter_full ? ST_OUT : ST_SRCH_A;
        else state_nxt = ST_BAS_ISS;
      end
      ST_BAS_ISS: state_nxt = (p_d == '0) ? ST_W_RD : ST_BAS_L;
      ST_BAS_L:   state_nxt = u_lt ? ST_OUT : ST_BAS_R;
      ST_BAS_R:   state_nxt = u_gt ? ST_OUT : ST_DEN;
      ST_DEN:     state_nxt = (den_c == '0) ? ST_OUT : ST_MUL_R;
      ST_MUL_R:   state_nxt = ST_DIV_R;
      ST_DIV_R: begin
        if (div_done) state_nxt = ST_MUL_L;
      end
      ST_MUL_L:   state_nxt = ST_DIV_L;
      ST_DIV_L: begin
        if (div_done) begin
          if (!r_last) state_nxt = ST_DEN;
          else if (j_r == p_d) state_nxt = ST_W_RD;
          else state_nxt = ST_BAS_ISS;
        end
      end
      ST_W_RD:  state_nxt = ST_W_MUL;
      ST_W_MUL: state_nxt = ST_W_ACC;
      ST_W_ACC: state_nxt = (k_r == p_d) ? ST_W_RND : ST_W_RD;
      ST_W_RND: state_nxt = (c_r == COORD_Z) ? ST_OUT : ST_W_RD;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer datapath and store controls
  always_comb begin
    item_nxt  = item_r;
    res_nxt   = res_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    span_nxt  = span_r;
    iter_nxt  = iter_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    saved_nxt = saved_r;
    cur_nxt   = cur_r;
    den_nxt   = den_r;
    rtv_nxt   = rtv_r;
    lfv_nxt   = lfv_r;
    nb_nxt    = nb_r;
    lf_nxt    = lf_r;
    rt_nxt    = rt_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    knot_addr = span_r;
    knot_we   = 1'b0;
    ctrl_we   = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) item_nxt = in_data;
      end
      ST_DECODE: begin
        res_nxt   = '0;
        knot_addr = p_k;
        case (item_r.command)
          CMD_LOAD_KNOT: begin
            if (idx_k_ok) knot_we = 1'b1;
            else res_nxt.status = STAT_BAD_INDEX;
          end
          CMD_LOAD_POINT: begin
            if (idx_c_ok) ctrl_we = 1'b1;
            else res_nxt.status = STAT_BAD_INDEX;
          end
          CMD_EVAL: begin
            if (cfg_bad) res_nxt.status = STAT_BAD_INDEX;
          end
          default: res_nxt.status = STAT_BAD_INDEX;
        endcase
      end
      ST_RNG_LO: begin
        // u below the first knot of the curve
        if (u_lt) res_nxt.status = STAT_BAD_U;
        knot_addr = n_k;
      end
      ST_RNG_HI: begin
        knot_addr = mid_pn;
        if (u_gt) begin
          res_nxt.status = STAT_BAD_U;
        end else if (!u_lt) begin
          // u on the last knot: clamp to the final span
          span_nxt  = n_k - KAW'(1);
          nb_nxt[0] = ONE_Q30;
          j_nxt     = DW'(1);
        end else begin
          low_nxt  = p_k;
          high_nxt = n_k;
          span_nxt = mid_pn;
          iter_nxt = '0;
        end
      end
      ST_SRCH_A: begin
        if (u_lt) begin
          knot_addr = mid_ls;
          if (iter_full) begin
            res_nxt.status = STAT_BAD_U;
          end else begin
            high_nxt = span_r;
            span_nxt = mid_ls;
            iter_nxt = iter_r + IT_W'(1);
          end
        end else begin
          knot_addr = span_r + KAW'(1);
        end
      end
      ST_SRCH_B: begin
        knot_addr = mid_sh;
        if (!u_lt) begin
          if (iter_full) begin
            res_nxt.status = STAT_BAD_U;
          end else begin
            low_nxt  = span_r;
            span_nxt = mid_sh;
            iter_nxt = iter_r + IT_W'(1);
          end
        end else begin
          nb_nxt[0] = ONE_Q30;
          j_nxt     = DW'(1);
        end
      end
      ST_BAS_ISS: begin
        knot_addr = span_r + KAW'(1) - j_k;
        if (p_d == '0) begin
          k_nxt   = '0;
          c_nxt   = COORD_X;
          acc_nxt = '0;
        end
      end
      ST_BAS_L: begin
        if (u_lt) res_nxt.status = STAT_BAD_U;
        lf_nxt[j_r] = u - knot_q_r;
        knot_addr   = span_r + j_k;
      end
      ST_BAS_R: begin
        if (u_gt) res_nxt.status = STAT_BAD_U;
        rt_nxt[j_r] = knot_q_r - u;
        r_nxt       = '0;
        saved_nxt   = '0;
      end
      ST_DEN: begin
        if (den_c == '0) res_nxt.status = STAT_BAD_U;
        den_nxt = den_c;
        cur_nxt = nb_r[r_r];
        rtv_nxt = rt_sel;
        lfv_nxt = lf_sel;
      end
      ST_MUL_R, ST_MUL_L: begin
        div_start = 1'b1;
      end
      ST_DIV_R: begin
        if (div_done) nb_nxt[r_r] = saved_r + div_quo;
      end
      ST_DIV_L: begin
        if (div_done) begin
          saved_nxt = div_quo;
          r_nxt     = r_r + DW'(1);
          if (r_last) begin
            nb_nxt[j_r] = div_quo;
            if (j_r == p_d) begin
              k_nxt   = '0;
              c_nxt   = COORD_X;
              acc_nxt = '0;
            end else begin
              j_nxt = j_r + DW'(1);
            end
          end
        end
      end
      ST_W_MUL: begin
        prod_nxt = mul_p;
      end
      ST_W_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        if (k_r != p_d) k_nxt = k_r + DW'(1);
      end
      ST_W_RND: begin
        case (c_r)
          COORD_X: res_nxt.point_x = sat_val;
          COORD_Y: res_nxt.point_y = sat_val;
          default: res_nxt.point_z = sat_val;
        endcase
        acc_nxt = '0;
        k_nxt   = '0;
        if (c_r == COORD_Z) begin
          res_nxt.span_found = 7'(span_r);
          res_nxt.status     = STAT_OK;
        end else begin
          c_nxt = c_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      deg_r       <= 2'd3;
      pc_r        <= 7'd4;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr[REG_SEL_BIT] == REG_DEGREE) deg_r <= pwdata[1:0];
        else pc_r <= pwdata[6:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    span_r  <= span_nxt;
    iter_r  <= iter_nxt;
    j_r     <= j_nxt;
    r_r     <= r_nxt;
    k_r     <= k_nxt;
    c_r     <= c_nxt;
    saved_r <= saved_nxt;
    cur_r   <= cur_nxt;
    den_r   <= den_nxt;
    rtv_r   <= rtv_nxt;
    lfv_r   <= lfv_nxt;
    nb_r    <= nb_nxt;
    lf_r    <= lf_nxt;
    rt_r    <= rt_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    if (out_load) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/bcpe_checker.sv =====
`include "assert_macros.svh"

module bcpe_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bcpe_pkg::out_item_t out_data,
  input logic                pready
);
  import bcpe_pkg::*;

  // one transaction in flight: accepting one closes the input side
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // any error result carries no point and no span
  `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && out_data.status != STAT_OK, out_data.point_x == 32'sd0 && out_data.point_y == 32'sd0 && out_data.point_z == 32'sd0 && out_data.span_found == 7'd0)

  // configuration port never waits
  `ASSERT_IMPLIES(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind bspline_curve_point_eval_core bcpe_checker u_bcpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
